// File: hdl/taylor_sine_cosine_unit_assert.svh
// Assertion macros shared by the Taylor sine and cosine unit.
// Depends on nothing; files that check their own logic include it by name.
`ifndef TAYLOR_SINE_COSINE_UNIT_ASSERT_SVH
`define TAYLOR_SINE_COSINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: hdl/tsc_pkg.sv
// Shared widths, constants and types of the Taylor sine and cosine unit.
// Depends on nothing; every other design file imports it.
package tsc_pkg;

    localparam int TERM_COUNT  = 16;
    localparam int TERM_LAST   = 2 * TERM_COUNT - 1;
    localparam int ANGLE_W     = 31;
    localparam int ANGLE_FRAC  = 28;
    localparam int FRAC_BITS   = 40;
    localparam int OUT_W       = 32;
    localparam int OUT_FRAC    = 30;
    localparam int ROUND_SHIFT = FRAC_BITS - OUT_FRAC;

    // Term magnitudes x^k/k! stay below 2^49 for any angle below 8.0.
    localparam int TERM_W  = 49;
    localparam int LO_W    = 25;
    localparam int HI_W    = TERM_W - LO_W;
    localparam int ACC_W   = 54;

    // The scaled product p*x is divided by k one chunk at a time.
    localparam int CHUNK_W     = 18;
    localparam int CHUNK_N     = 3;
    localparam int PROD_W      = CHUNK_W * CHUNK_N;
    localparam int SUM_W       = ANGLE_FRAC + PROD_W;
    localparam int IDX_W       = $clog2(2 * TERM_COUNT);
    localparam int DIGIT_W     = IDX_W + CHUNK_W;
    localparam int RECIP_SHIFT = DIGIT_W + IDX_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [TERM_W-1:0]       TERM_ONE   = TERM_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_ONE    = ACC_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ROUND_SHIFT - 1);
    localparam logic signed [OUT_W-1:0] OUT_ONE    = OUT_W'(1) << OUT_FRAC;

    typedef struct packed {
        logic [ANGLE_W-1:0]       angle;
        logic signed [ACC_W-1:0]  sin_acc;
        logic signed [ACC_W-1:0]  cos_acc;
    } t_item;

    typedef struct packed {
        t_item               item;
        logic [TERM_W-1:0]   term;
    } t_cell_bus;

endpackage

// File: hdl/taylor_sine_cosine_unit.sv
// Top level of the Taylor sine and cosine unit: a chain of term cells and an output register.
// Depends on tsc_pkg, tsc_term_cell, tsc_out_stage and taylor_sine_cosine_unit_assert.svh.
//
// The angle channel (i_angle_valid, o_angle_ready, i_angle) takes one unsigned Q3.28
// angle per transaction. The result channel (o_result_valid, i_result_ready) returns
// one transaction per angle, in order, carrying o_sine_value and o_cosine_value as
// signed Q2.30 values held to the range from minus one to plus one.
// A new angle can be taken in every cycle in which o_angle_ready is high. Each term x^k/k!
// has its own cell of eight stages (two for the product with the angle, two per chunk of
// the division by k), and there are 2*TERM_COUNT-1 cells.
// Reset empties every stage and the output register; nothing else needs clearing.
// When the receiver stalls, the result waits in the output register and the chain keeps
// moving until a finished item reaches its last stage; only then does o_angle_ready fall,
// and it rises again in the cycle in which the receiver takes the waiting result.
`include "taylor_sine_cosine_unit_assert.svh"

module taylor_sine_cosine_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_angle_valid,
    output logic                               o_angle_ready,
    input  logic [tsc_pkg::ANGLE_W-1:0]        i_angle,
    output logic                               o_result_valid,
    input  logic                               i_result_ready,
    output logic signed [tsc_pkg::OUT_W-1:0]   o_sine_value,
    output logic signed [tsc_pkg::OUT_W-1:0]   o_cosine_value
);
    import tsc_pkg::*;

    logic       w_valid [TERM_LAST+1];
    t_cell_bus  w_bus   [TERM_LAST+1];
    logic       w_take;
    logic       w_adv;
    logic       w_last_valid;

    assign w_last_valid  = w_valid[TERM_LAST];
    assign w_adv         = !w_last_valid || w_take;
    assign o_angle_ready = w_adv;

    // The zeroth term is one and goes straight into the cosine sum.
    assign w_bus[0]   = {i_angle, {ACC_W{1'b0}}, ACC_ONE, TERM_ONE};
    assign w_valid[0] = i_angle_valid;

    for (genvar g = 0; g < TERM_LAST; g++) begin : g_cell
        localparam int     TermIdx = g + 1;
        localparam longint Recip   = ((longint'(1) << RECIP_SHIFT) + TermIdx - 1) / TermIdx;

        tsc_term_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_term_idx (IDX_W'(TermIdx)),
            .i_recip    (RECIP_W'(Recip)),
            .i_valid    (w_valid[g]),
            .i_bus      (w_bus[g]),
            .o_valid    (w_valid[g+1]),
            .o_bus      (w_bus[g+1])
        );
    end

    tsc_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_last_valid),
        .i_item         (w_bus[TERM_LAST].item),
        .i_ready        (i_result_ready),
        .o_take         (w_take),
        .o_valid        (o_result_valid),
        .o_sine_value   (o_sine_value),
        .o_cosine_value (o_cosine_value)
    );

    `TSC_ASSERT_IMPLY(a_stall_blocks_input, i_clk, i_rst_n, w_last_valid && !w_take, !o_angle_ready)
    `TSC_ASSERT_NEXT(a_last_item_delivered, i_clk, i_rst_n, w_last_valid && w_adv, o_result_valid)

endmodule

// File: hdl/tsc_term_cell.sv
// One cell of the term chain: forms x^k/k! from the previous term and adds it to a sum.
// Depends on tsc_pkg and on the assertion macros in taylor_sine_cosine_unit_assert.svh.
`include "taylor_sine_cosine_unit_assert.svh"

module tsc_term_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [tsc_pkg::IDX_W-1:0]    i_term_idx,
    input  logic [tsc_pkg::RECIP_W-1:0]  i_recip,
    input  logic                         i_valid,
    input  tsc_pkg::t_cell_bus           i_bus,
    output logic                         o_valid,
    output tsc_pkg::t_cell_bus           o_bus
);
    import tsc_pkg::*;

    localparam int HI_PROD_W = HI_W + ANGLE_W;
    localparam int LO_PROD_W = LO_W + ANGLE_W;
    localparam int MUL_W     = DIGIT_W + RECIP_W;

    logic                  r_m_valid;
    t_item                 r_m_item;
    logic [HI_PROD_W-1:0]  r_m_hi;
    logic [LO_PROD_W-1:0]  r_m_lo;
    logic [SUM_W-1:0]      w_sum;
    logic                  r_q_valid;
    t_item                 r_q_item;
    logic [PROD_W-1:0]     r_q_prod;

    logic                  w_c_valid [CHUNK_N];
    t_item                 w_c_item  [CHUNK_N];
    logic [PROD_W-1:0]     w_c_prod  [CHUNK_N];
    logic [PROD_W-1:0]     w_c_quo   [CHUNK_N];
    logic [IDX_W-1:0]      w_c_rem   [CHUNK_N];

    // The previous term is split in two so that each partial product stays narrow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_adv) begin
            r_m_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m_item <= i_bus.item;
            r_m_hi   <= HI_PROD_W'(i_bus.term[TERM_W-1:LO_W]) * HI_PROD_W'(i_bus.item.angle);
            r_m_lo   <= LO_PROD_W'(i_bus.term[LO_W-1:0]) * LO_PROD_W'(i_bus.item.angle);
        end
    end

    assign w_sum = (SUM_W'(r_m_hi) << LO_W) + SUM_W'(r_m_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (i_adv) begin
            r_q_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_q_item <= r_m_item;
            r_q_prod <= w_sum[SUM_W-1:ANGLE_FRAC];
        end
    end

    assign w_c_valid[0] = r_q_valid;
    assign w_c_item[0]  = r_q_item;
    assign w_c_prod[0]  = r_q_prod;
    assign w_c_quo[0]   = '0;
    assign w_c_rem[0]   = '0;

    // Long division by the term index, one chunk per pair of stages, using a reciprocal of
    // the index, rounded up, that gives the exact quotient for each partial dividend.
    for (genvar j = 0; j < CHUNK_N; j++) begin : g_chunk
        logic                 r_a_valid;
        t_item                r_a_item;
        logic [PROD_W-1:0]    r_a_quo;
        logic [MUL_W-1:0]     r_a_mul;
        logic [DIGIT_W-1:0]   w_digit;
        logic [CHUNK_W-1:0]   w_quo;
        logic [PROD_W-1:0]    w_quo_all;

        assign w_digit = {w_c_rem[j], w_c_prod[j][PROD_W-1 -: CHUNK_W]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_valid <= 1'b0;
            end else if (i_adv) begin
                r_a_valid <= w_c_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_a_item  <= w_c_item[j];
                r_a_quo   <= w_c_quo[j];
                r_a_mul   <= MUL_W'(w_digit) * MUL_W'(i_recip);
            end
        end

        assign w_quo     = r_a_mul[RECIP_SHIFT +: CHUNK_W];
        assign w_quo_all = {r_a_quo[PROD_W-CHUNK_W-1:0], w_quo};

        if (j < CHUNK_N - 1) begin : g_mid
            logic                 r_b_valid;
            t_item                r_b_item;
            logic [DIGIT_W-1:0]   r_a_digit;
            logic [PROD_W-1:0]    r_a_prod;
            logic [PROD_W-1:0]    r_b_prod;
            logic [PROD_W-1:0]    r_b_quo;
            logic [IDX_W-1:0]     r_b_rem;
            logic [DIGIT_W-1:0]   w_back;

            assign w_back = DIGIT_W'(w_quo) * DIGIT_W'(i_term_idx);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_b_valid <= 1'b0;
                end else if (i_adv) begin
                    r_b_valid <= r_a_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_a_digit <= w_digit;
                    r_a_prod <= w_c_prod[j] << CHUNK_W;
                    r_b_prod <= r_a_prod;
                    r_b_item <= r_a_item;
                    r_b_quo  <= w_quo_all;
                    r_b_rem  <= IDX_W'(r_a_digit - w_back);
                end
            end

            assign w_c_valid[j+1] = r_b_valid;
            assign w_c_item[j+1]  = r_b_item;
            assign w_c_prod[j+1]  = r_b_prod;
            assign w_c_quo[j+1]   = r_b_quo;
            assign w_c_rem[j+1]   = r_b_rem;
        end else begin : g_last
            logic                     r_f_valid;
            t_cell_bus                r_f_bus;
            logic [TERM_W-1:0]        w_term;
            logic signed [ACC_W-1:0]  w_step;
            t_item                    w_item;

            assign w_term = w_quo_all[TERM_W-1:0];
            assign w_step = $signed(ACC_W'(w_term));

            // Odd terms feed the sine and even terms the cosine; bit one of k gives the sign.
            always_comb begin
                w_item = r_a_item;
                if (i_term_idx[0]) begin
                    w_item.sin_acc = i_term_idx[1] ? r_a_item.sin_acc - w_step
                                                   : r_a_item.sin_acc + w_step;
                end else begin
                    w_item.cos_acc = i_term_idx[1] ? r_a_item.cos_acc - w_step
                                                   : r_a_item.cos_acc + w_step;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_f_valid <= 1'b0;
                end else if (i_adv) begin
                    r_f_valid <= r_a_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_f_bus.item <= w_item;
                    r_f_bus.term <= w_term;
                end
            end

            assign o_valid = r_f_valid;
            assign o_bus   = r_f_bus;
        end
    end

    for (genvar j = 0; j < CHUNK_N; j++) begin : g_check
        logic w_rem_ok;
        assign w_rem_ok = w_c_rem[j] < i_term_idx;
        `TSC_ASSERT_IMPLY(a_rem_below_divisor, i_clk, i_rst_n, w_c_valid[j], w_rem_ok)
    end

    `TSC_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, !i_adv, o_valid == $past(o_valid))

endmodule

// File: hdl/tsc_out_stage.sv
// Output register of the Taylor sine and cosine unit: rounds and saturates both sums to Q2.30.
// Depends on tsc_pkg and on the assertion macros in taylor_sine_cosine_unit_assert.svh.
`include "taylor_sine_cosine_unit_assert.svh"

module tsc_out_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  tsc_pkg::t_item                     i_item,
    input  logic                               i_ready,
    output logic                               o_take,
    output logic                               o_valid,
    output logic signed [tsc_pkg::OUT_W-1:0]   o_sine_value,
    output logic signed [tsc_pkg::OUT_W-1:0]   o_cosine_value
);
    import tsc_pkg::*;

    logic                     r_valid;
    logic signed [OUT_W-1:0]  r_sine;
    logic signed [OUT_W-1:0]  r_cosine;
    logic                     w_in_range;

    // Saturates at plus or minus one and otherwise rounds to nearest, ties upward.
    function automatic logic signed [OUT_W-1:0] to_q230(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0]  biased;
        logic signed [OUT_W-1:0]  res;
        biased = acc + ROUND_HALF;
        if (acc >= ACC_ONE) begin
            res = OUT_ONE;
        end else if (acc <= -ACC_ONE) begin
            res = -OUT_ONE;
        end else begin
            res = biased[ROUND_SHIFT +: OUT_W];
        end
        return res;
    endfunction

    assign o_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_sine   <= to_q230(i_item.sin_acc);
            r_cosine <= to_q230(i_item.cos_acc);
        end
    end

    assign o_valid        = r_valid;
    assign o_sine_value   = r_sine;
    assign o_cosine_value = r_cosine;

    assign w_in_range = (o_sine_value <= OUT_ONE) && (o_sine_value >= -OUT_ONE)
                     && (o_cosine_value <= OUT_ONE) && (o_cosine_value >= -OUT_ONE);

    `TSC_ASSERT_IMPLY(a_results_saturated, i_clk, i_rst_n, o_valid, w_in_range)

endmodule
